// ===== rtl/mms_pkg.sv =====
// Shared types, constants and helper functions of the momentum scroll block.
`default_nettype none
package mms_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int DELTA_WIDTH = 12;
    localparam int STATE_W     = 32;
    localparam int MOVE_W      = 8;
    localparam int BUTTON_W    = 8;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int MIDDLE_BIT  = 2;
    localparam int MOVE_LIMIT  = 127;

    // 1.00 needs one integer bit above the fraction
    localparam int GAIN_W      = FRAC_BITS + 1;
    localparam int SPEED_GAIN_W = GAIN_W + CFG_W;
    localparam int MUL_B_W     = SPEED_GAIN_W + 1;
    localparam int PROD_W      = STATE_W + MUL_B_W;
    localparam int SENS_MAX    = 10;
    localparam int MOVE_PROD_W = DELTA_WIDTH + CFG_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCROLL_SENS  = 3'd0,
        CFG_SCROLL_SPEED = 3'd1,
        CFG_POINTER_SPEED = 3'd2,
        CFG_FLIP_X       = 3'd3,
        CFG_FLIP_Y       = 3'd4,
        CFG_FLIP_SCROLL  = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOVE,
        ST_MUL_DY,
        ST_VEL_ADD,
        ST_MUL_VEL,
        ST_VEL_SCALE,
        ST_ACC_ADD,
        ST_WHEEL,
        ST_MUL_V70,
        ST_VEL_IDLE,
        ST_ACC_IDLE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_DY_GAIN,
        MUL_VEL_K82,
        MUL_VEL_K70,
        MUL_ACC_K70
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     calc_move;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     vel_add;
        logic     vel_scale;
        logic     acc_add;
        logic     acc_wheel;
        logic     acc_scale;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic scroll;
        logic out_free;
    } dp_status_t;

    // round-to-nearest fixed-point value of hundredths
    function automatic logic [GAIN_W-1:0] fx_const(input int unsigned h);
        logic [63:0] t;
        t = ((64'(h) << FRAC_BITS) + 64'd50) / 64'd100;
        return t[GAIN_W-1:0];
    endfunction

    typedef logic [GAIN_W-1:0] gain_tab_t [0:SENS_MAX];

    localparam gain_tab_t GAIN_TAB = '{
        fx_const(4),  fx_const(6),  fx_const(8),  fx_const(10),
        fx_const(14), fx_const(18), fx_const(25), fx_const(35),
        fx_const(50), fx_const(75), fx_const(100)
    };

    localparam logic [GAIN_W-1:0] K_DECAY_SCROLL = fx_const(82);
    localparam logic [GAIN_W-1:0] K_DECAY_IDLE   = fx_const(70);
    localparam logic signed [STATE_W-1:0] T_VEL_SNAP =
        signed'(STATE_W'(fx_const(3)));
    localparam logic signed [STATE_W-1:0] T_ACC_SNAP =
        signed'(STATE_W'(fx_const(5)));

    function automatic logic signed [STATE_W-1:0] sat32(
        input logic signed [PROD_W:0] s);
        logic signed [PROD_W:0] hi;
        logic signed [PROD_W:0] lo;
        hi = (PROD_W+1)'(signed'(32'h7fff_ffff));
        lo = (PROD_W+1)'(signed'(32'h8000_0000));
        if (s > hi) begin
            return signed'(32'h7fff_ffff);
        end
        if (s < lo) begin
            return signed'(32'h8000_0000);
        end
        return signed'(s[STATE_W-1:0]);
    endfunction

    // product / 2^FRAC_BITS, truncated toward zero
    function automatic logic signed [STATE_W-1:0] fx_trunc(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] b;
        b = p[PROD_W-1] ? p + PROD_W'((64'd1 << FRAC_BITS) - 64'd1) : p;
        return signed'(b[FRAC_BITS+STATE_W-1:FRAC_BITS]);
    endfunction

    function automatic logic fx_small(input logic signed [STATE_W-1:0] v,
                                      input logic signed [STATE_W-1:0] t);
        return (v > -t) && (v < t);
    endfunction

    function automatic logic signed [MOVE_W-1:0] clamp_move(
        input logic signed [STATE_W-1:0] v);
        if (v > STATE_W'(MOVE_LIMIT)) begin
            return MOVE_W'(MOVE_LIMIT);
        end
        if (v < -(STATE_W'(MOVE_LIMIT))) begin
            return -(MOVE_W'(MOVE_LIMIT));
        end
        return signed'(v[MOVE_W-1:0]);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mms_dp.sv =====
// Datapath: config registers, scroll state, shared multiplier, result register.
`default_nettype none
module mms_dp (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       cfg_wr_en,
    input  wire logic [mms_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  wire logic [mms_pkg::CFG_W-1:0]                  cfg_wr_data,
    input  wire logic signed [mms_pkg::DELTA_WIDTH-1:0]     s_raw_dx,
    input  wire logic signed [mms_pkg::DELTA_WIDTH-1:0]     s_raw_dy,
    input  wire logic [mms_pkg::BUTTON_W-1:0]               s_button_bits,
    input  wire mms_pkg::dp_cmd_t                           cmd,
    output mms_pkg::dp_status_t                             status,
    output logic                                            m_valid,
    input  wire logic                                       m_ready,
    output logic [mms_pkg::BUTTON_W-1:0]                    m_button_report,
    output logic signed [mms_pkg::MOVE_W-1:0]               m_move_x,
    output logic signed [mms_pkg::MOVE_W-1:0]               m_move_y,
    output logic signed [mms_pkg::MOVE_W-1:0]               m_wheel_step,
    output logic                                            m_activity
);

    logic [mms_pkg::CFG_W-1:0] sens_reg;
    logic [mms_pkg::CFG_W-1:0] sspeed_reg;
    logic [mms_pkg::CFG_W-1:0] pspeed_reg;
    logic flip_x_reg;
    logic flip_y_reg;
    logic flip_scroll_reg;

    logic signed [mms_pkg::DELTA_WIDTH-1:0] dx_reg;
    logic signed [mms_pkg::DELTA_WIDTH-1:0] dy_reg;
    logic [mms_pkg::BUTTON_W-1:0]           buttons_reg;
    logic                                   scroll_reg;

    logic [mms_pkg::SPEED_GAIN_W-1:0]       gain_reg;
    logic signed [mms_pkg::PROD_W-1:0]      prod_reg;
    logic signed [mms_pkg::STATE_W-1:0]     vel_reg;
    logic signed [mms_pkg::STATE_W-1:0]     vel_next;
    logic signed [mms_pkg::STATE_W-1:0]     acc_reg;
    logic signed [mms_pkg::STATE_W-1:0]     acc_next;

    logic signed [mms_pkg::MOVE_W-1:0]      mx_reg;
    logic signed [mms_pkg::MOVE_W-1:0]      my_reg;
    logic signed [mms_pkg::MOVE_W-1:0]      wheel_reg;
    logic signed [mms_pkg::MOVE_W-1:0]      wheel_next;

    logic [mms_pkg::CFG_W-1:0]              sens_sel;
    logic signed [mms_pkg::STATE_W-1:0]     mul_a;
    logic signed [mms_pkg::MUL_B_W-1:0]     mul_b;
    logic signed [mms_pkg::MOVE_PROD_W-1:0] mx_prod;
    logic signed [mms_pkg::MOVE_PROD_W-1:0] my_prod;
    logic signed [mms_pkg::MOVE_W-1:0]      mx_clamp;
    logic signed [mms_pkg::MOVE_W-1:0]      my_clamp;
    logic signed [mms_pkg::STATE_W-1:0]     vel_scaled;
    logic signed [mms_pkg::STATE_W-1:0]     acc_scaled;
    logic signed [mms_pkg::STATE_W-1:0]     acc_bias;
    logic signed [mms_pkg::STATE_W-1:0]     whole;
    logic signed [mms_pkg::MOVE_W-1:0]      whole_clamp;
    logic [mms_pkg::BUTTON_W-1:0]           middle_mask;

    // config writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg        <= mms_pkg::CFG_W'(5);
            sspeed_reg      <= mms_pkg::CFG_W'(1);
            pspeed_reg      <= mms_pkg::CFG_W'(1);
            flip_x_reg      <= 1'b0;
            flip_y_reg      <= 1'b0;
            flip_scroll_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (mms_pkg::cfg_idx_t'(cfg_index))
                mms_pkg::CFG_SCROLL_SENS:   sens_reg        <= cfg_wr_data;
                mms_pkg::CFG_SCROLL_SPEED:  sspeed_reg      <= cfg_wr_data;
                mms_pkg::CFG_POINTER_SPEED: pspeed_reg      <= cfg_wr_data;
                mms_pkg::CFG_FLIP_X:        flip_x_reg      <= cfg_wr_data[0];
                mms_pkg::CFG_FLIP_Y:        flip_y_reg      <= cfg_wr_data[0];
                mms_pkg::CFG_FLIP_SCROLL:   flip_scroll_reg <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign sens_sel = (sens_reg > mms_pkg::CFG_W'(mms_pkg::SENS_MAX)) ?
                      mms_pkg::CFG_W'(mms_pkg::SENS_MAX) : sens_reg;

    // pointer motion
    always_comb begin
        mx_prod  = mms_pkg::MOVE_PROD_W'(dx_reg) *
                   mms_pkg::MOVE_PROD_W'(signed'({1'b0, pspeed_reg}));
        my_prod  = mms_pkg::MOVE_PROD_W'(dy_reg) *
                   mms_pkg::MOVE_PROD_W'(signed'({1'b0, pspeed_reg}));
        mx_clamp = mms_pkg::clamp_move(mms_pkg::STATE_W'(mx_prod));
        my_clamp = mms_pkg::clamp_move(mms_pkg::STATE_W'(my_prod));
        if (flip_x_reg) begin
            mx_clamp = -mx_clamp;
        end
        if (flip_y_reg) begin
            my_clamp = -my_clamp;
        end
    end

    // shared multiplier operands
    always_comb begin
        case (cmd.mul_sel)
            mms_pkg::MUL_DY_GAIN: begin
                mul_a = mms_pkg::STATE_W'(dy_reg);
                mul_b = signed'({1'b0, gain_reg});
            end
            mms_pkg::MUL_VEL_K82: begin
                mul_a = vel_reg;
                mul_b = signed'(mms_pkg::MUL_B_W'(mms_pkg::K_DECAY_SCROLL));
            end
            mms_pkg::MUL_VEL_K70: begin
                mul_a = vel_reg;
                mul_b = signed'(mms_pkg::MUL_B_W'(mms_pkg::K_DECAY_IDLE));
            end
            mms_pkg::MUL_ACC_K70: begin
                mul_a = acc_reg;
                mul_b = signed'(mms_pkg::MUL_B_W'(mms_pkg::K_DECAY_IDLE));
            end
            default: begin
                mul_a = vel_reg;
                mul_b = '0;
            end
        endcase
    end

    // state updates
    always_comb begin
        vel_scaled  = mms_pkg::fx_trunc(prod_reg);
        acc_scaled  = mms_pkg::fx_trunc(prod_reg);
        acc_bias    = acc_reg + (acc_reg[mms_pkg::STATE_W-1] ?
                      mms_pkg::STATE_W'((64'd1 << mms_pkg::FRAC_BITS) - 64'd1) :
                      mms_pkg::STATE_W'(0));
        whole       = acc_bias >>> mms_pkg::FRAC_BITS;
        whole_clamp = mms_pkg::clamp_move(whole);
        vel_next    = vel_reg;
        acc_next    = acc_reg;
        wheel_next  = wheel_reg;
        if (cmd.vel_add) begin
            vel_next = mms_pkg::sat32((mms_pkg::PROD_W+1)'(prod_reg) +
                                      (mms_pkg::PROD_W+1)'(vel_reg));
        end
        if (cmd.vel_scale) begin
            vel_next = vel_scaled;
            // scroll mode only snaps while the wheel axis is idle
            if ((!scroll_reg || dy_reg == '0) &&
                mms_pkg::fx_small(vel_scaled, mms_pkg::T_VEL_SNAP)) begin
                vel_next = '0;
            end
        end
        if (cmd.acc_add) begin
            acc_next = mms_pkg::sat32((mms_pkg::PROD_W+1)'(acc_reg) +
                                      (mms_pkg::PROD_W+1)'(vel_reg));
        end
        if (cmd.acc_wheel) begin
            acc_next   = acc_reg -
                         (mms_pkg::STATE_W'(whole_clamp) <<< mms_pkg::FRAC_BITS);
            wheel_next = flip_scroll_reg ? -whole_clamp : whole_clamp;
        end
        if (cmd.acc_scale) begin
            acc_next = acc_scaled;
            if (mms_pkg::fx_small(acc_scaled, mms_pkg::T_ACC_SNAP)) begin
                acc_next = '0;
            end
        end
        if (cmd.load_in) begin
            wheel_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_reg <= '0;
            acc_reg <= '0;
        end else begin
            vel_reg <= vel_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        wheel_reg <= wheel_next;
        if (cmd.load_in) begin
            dx_reg      <= s_raw_dx;
            dy_reg      <= s_raw_dy;
            buttons_reg <= s_button_bits;
            scroll_reg  <= s_button_bits[mms_pkg::MIDDLE_BIT];
        end
        if (cmd.calc_move) begin
            mx_reg   <= scroll_reg ? '0 : mx_clamp;
            my_reg   <= scroll_reg ? '0 : my_clamp;
            // widen both factors first: 1.00 times 15 needs the full gain width
            gain_reg <= mms_pkg::SPEED_GAIN_W'(mms_pkg::GAIN_TAB[sens_sel]) *
                        mms_pkg::SPEED_GAIN_W'(sspeed_reg);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // result register
    assign middle_mask = scroll_reg ?
                         mms_pkg::BUTTON_W'(1 << mms_pkg::MIDDLE_BIT) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_button_report <= buttons_reg & ~middle_mask;
            m_move_x        <= mx_reg;
            m_move_y        <= my_reg;
            m_wheel_step    <= wheel_reg;
            m_activity      <= (mx_reg != '0) || (my_reg != '0) ||
                               (wheel_reg != '0);
        end
    end

    assign status.scroll   = scroll_reg;
    assign status.out_free = !m_valid || m_ready;

endmodule
`default_nettype wire

// ===== rtl/mms_ctrl.sv =====
// Sequencer that steps the datapath through one report tick.
`default_nettype none
module mms_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mms_pkg::dp_status_t status,
    output mms_pkg::dp_cmd_t         cmd
);

    mms_pkg::state_t state_reg;
    mms_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mms_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = mms_pkg::MUL_DY_GAIN;
        s_ready     = 1'b0;
        case (state_reg)
            mms_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
                if (s_valid) begin
                    state_next = mms_pkg::ST_MOVE;
                end
            end
            mms_pkg::ST_MOVE: begin
                cmd.calc_move = 1'b1;
                state_next = status.scroll ? mms_pkg::ST_MUL_DY : mms_pkg::ST_MUL_V70;
            end
            mms_pkg::ST_MUL_DY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mms_pkg::MUL_DY_GAIN;
                state_next  = mms_pkg::ST_VEL_ADD;
            end
            mms_pkg::ST_VEL_ADD: begin
                cmd.vel_add = 1'b1;
                state_next  = mms_pkg::ST_MUL_VEL;
            end
            mms_pkg::ST_MUL_VEL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mms_pkg::MUL_VEL_K82;
                state_next  = mms_pkg::ST_VEL_SCALE;
            end
            mms_pkg::ST_VEL_SCALE: begin
                cmd.vel_scale = 1'b1;
                state_next    = mms_pkg::ST_ACC_ADD;
            end
            mms_pkg::ST_ACC_ADD: begin
                cmd.acc_add = 1'b1;
                state_next  = mms_pkg::ST_WHEEL;
            end
            mms_pkg::ST_WHEEL: begin
                cmd.acc_wheel = 1'b1;
                state_next    = mms_pkg::ST_OUT;
            end
            mms_pkg::ST_MUL_V70: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = mms_pkg::MUL_VEL_K70;
                state_next  = mms_pkg::ST_VEL_IDLE;
            end
            mms_pkg::ST_VEL_IDLE: begin
                cmd.vel_scale = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = mms_pkg::MUL_ACC_K70;
                state_next    = mms_pkg::ST_ACC_IDLE;
            end
            mms_pkg::ST_ACC_IDLE: begin
                cmd.acc_scale = 1'b1;
                state_next    = mms_pkg::ST_OUT;
            end
            mms_pkg::ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = mms_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/mouse_motion_momentum_scroll.sv =====
// Top level: pointer motion with middle-button momentum scroll.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   s_      | in        | s_valid / s_ready  | s_raw_dx, s_raw_dy, s_button_bits
//   m_      | out       | m_valid / m_ready  | m_button_report, m_move_x, m_move_y,
//           |           |                    | m_wheel_step, m_activity
//   cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// One request at a time: after the accept cycle the sequencer walks the single
// shared 32x22 multiplier, with a longer run of steps in scroll mode than outside it.
// Result sits in an output register; a new request is taken while it waits,
// and the tick stalls in its final step only if the old result is still held.
// aresetn (synchronous) clears velocity, accumulator and config to defaults.
`default_nettype none
module mouse_motion_momentum_scroll (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // config write port
    input  wire logic                                    cfg_wr_en,
    input  wire logic [mms_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [mms_pkg::CFG_W-1:0]               cfg_wr_data,
    // request in
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [mms_pkg::DELTA_WIDTH-1:0]  s_raw_dx,
    input  wire logic signed [mms_pkg::DELTA_WIDTH-1:0]  s_raw_dy,
    input  wire logic [mms_pkg::BUTTON_W-1:0]            s_button_bits,
    // report out
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [mms_pkg::BUTTON_W-1:0]                 m_button_report,
    output logic signed [mms_pkg::MOVE_W-1:0]            m_move_x,
    output logic signed [mms_pkg::MOVE_W-1:0]            m_move_y,
    output logic signed [mms_pkg::MOVE_W-1:0]            m_wheel_step,
    output logic                                         m_activity
);

    mms_pkg::dp_cmd_t    cmd;
    mms_pkg::dp_status_t status;

    // sequencer: one state per multiply / update step, ST_VEL_IDLE does both
    mms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Q16.16 velocity / accumulator, motion clamp, result register
    mms_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_raw_dx        (s_raw_dx),
        .s_raw_dy        (s_raw_dy),
        .s_button_bits   (s_button_bits),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_button_report (m_button_report),
        .m_move_x        (m_move_x),
        .m_move_y        (m_move_y),
        .m_wheel_step    (m_wheel_step),
        .m_activity      (m_activity)
    );

endmodule
`default_nettype wire
